>>> rtl/core/flvtp_pkg.sv
// Shared types, constants and decode helpers for the FLV tag stream parser.
package flvtp_pkg;

   localparam int DATA_W   = 8;
   localparam int STATUS_W = 3;
   localparam int RSP_W    = 168;

   localparam logic [7:0] SIG_F = 8'h46;
   localparam logic [7:0] SIG_L = 8'h4C;
   localparam logic [7:0] SIG_V = 8'h56;

   localparam logic [31:0] HDR_MIN_OFFSET = 32'd9;
   localparam logic [31:0] TAG_HDR_BYTES  = 32'd11;

   localparam logic [7:0] TAG_AUDIO = 8'd8;
   localparam logic [7:0] TAG_VIDEO = 8'd9;

   typedef enum logic [3:0] {
      PH_SIG,
      PH_VER,
      PH_FLAGS,
      PH_OFFSET,
      PH_HSKIP,
      PH_HPREV,
      PH_TTYPE,
      PH_TLEN,
      PH_TSTAMP,
      PH_TRES,
      PH_PAYLOAD,
      PH_TPREV,
      PH_HALT
   } phase_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_HDR_OK      = 3'd0,
      ST_TAG_OK      = 3'd1,
      ST_BAD_SIG     = 3'd2,
      ST_OFFSET_LOW  = 3'd3,
      ST_HDR_PREVLEN = 3'd4,
      ST_TAG_PREVLEN = 3'd5
   } status_type;

   function automatic logic [15:0] audio_rate(input logic [1:0] code);
      logic [15:0] hz;
      case (code)
         2'd0:    hz = 16'd5500;
         2'd1:    hz = 16'd11000;
         2'd2:    hz = 16'd22000;
         2'd3:    hz = 16'd44000;
         default: hz = 16'd0;
      endcase
      return hz;
   endfunction

endpackage

>>> rtl/core/flv_tag_stream_parser.sv
// FLV tag stream parser: byte-wide FLV input, one result beat per header or tag.
//
// req_*: one file byte per beat in req_tdata[7:0].
// rsp_*: one beat after the file header, one per tag, one on an error.
//   rsp_tuser carries the status code; rsp_tdata carries the captured header
//   and tag fields and the decoded audio/video flags of the first payload byte.
// Throughput: one byte per clock while the spare register is empty; the whole
//   parse step for a byte sits between the state registers and the result register.
// Latency: a result appears on rsp the cycle after the byte that completes it,
//   unless an earlier result is still waiting there.
// Output stage: the result register plus one spare register. A result that
//   arrives while the receiver stalls the result register goes to the spare;
//   req_tready drops only while the spare is full and comes back the cycle
//   after the receiver takes a beat. req_tready does not depend on rsp_tready.
// Reset (synchronous, active high) returns to the signature check with all
//   captured fields at zero and both output registers empty; req_tready is low
//   during reset.
// After an error beat the block swallows all further bytes without results
//   until the next reset.
module flv_tag_stream_parser (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [flvtp_pkg::DATA_W-1:0]      req_tdata,   // [7:0] data_byte
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] tag_type, [31:8] data_size, [55:32] time_stamp, [87:56] reserved_word,
   // [95:88] header_version, [103:96] header_flags, [135:104] header_offset,
   // [139:136] media_codec, [141:140] audio_channels, [157:142] audio_rate_hz,
   // [161:158] video_ftype, [167:162] zero
   output logic [flvtp_pkg::RSP_W-1:0]       rsp_tdata,
   output logic [flvtp_pkg::STATUS_W-1:0]    rsp_tuser    // [2:0] status
);

   flvtp_pkg::phase_type phase_ff, phase_in;
   logic [31:0] count_ff, count_in;
   logic [31:0] offset_ff, offset_in;
   logic [7:0]  version_ff, version_in;
   logic [7:0]  flags_ff, flags_in;
   logic [7:0]  type_ff, type_in;
   logic [23:0] length_ff, length_in;
   logic [23:0] stamp_ff, stamp_in;
   logic [31:0] resvd_ff, resvd_in;
   logic [7:0]  first_ff, first_in;
   logic [31:0] prev_ff, prev_in;

   logic        accept;
   logic [7:0]  b;
   logic [7:0]  want;
   logic        res_valid;
   flvtp_pkg::status_type res_status;
   logic [flvtp_pkg::RSP_W-1:0] res_data;

   logic [3:0]  codec;
   logic [1:0]  chans;
   logic [15:0] rate;
   logic [3:0]  ftype;

   logic        rsp_valid_ff;
   logic [flvtp_pkg::RSP_W-1:0]    rsp_data_ff;
   logic [flvtp_pkg::STATUS_W-1:0] rsp_user_ff;
   logic        skid_valid_ff;
   logic [flvtp_pkg::RSP_W-1:0]    skid_data_ff;
   logic [flvtp_pkg::STATUS_W-1:0] skid_user_ff;
   logic        out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !reset && !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign b          = req_tdata;

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      offset_in  = offset_ff;
      version_in = version_ff;
      flags_in   = flags_ff;
      type_in    = type_ff;
      length_in  = length_ff;
      stamp_in   = stamp_ff;
      resvd_in   = resvd_ff;
      first_in   = first_ff;
      prev_in    = prev_ff;
      res_valid  = 1'b0;
      res_status = flvtp_pkg::ST_HDR_OK;
      case (count_ff[1:0])
         2'd0:    want = flvtp_pkg::SIG_F;
         2'd1:    want = flvtp_pkg::SIG_L;
         default: want = flvtp_pkg::SIG_V;
      endcase
      if (accept) begin
         case (phase_ff)
            flvtp_pkg::PH_SIG: begin
               if (b != want) begin
                  res_valid  = 1'b1;
                  res_status = flvtp_pkg::ST_BAD_SIG;
                  phase_in   = flvtp_pkg::PH_HALT;
               end else if (count_ff[1:0] == 2'd2) begin
                  count_in = '0;
                  phase_in = flvtp_pkg::PH_VER;
               end else begin
                  count_in = count_ff + 32'd1;
               end
            end
            flvtp_pkg::PH_VER: begin
               version_in = b;
               phase_in   = flvtp_pkg::PH_FLAGS;
            end
            flvtp_pkg::PH_FLAGS: begin
               flags_in = b;
               count_in = '0;
               phase_in = flvtp_pkg::PH_OFFSET;
            end
            flvtp_pkg::PH_OFFSET: begin
               offset_in = {offset_ff[23:0], b};
               if (count_ff[1:0] == 2'd3) begin
                  count_in = '0;
                  if (offset_in < flvtp_pkg::HDR_MIN_OFFSET) begin
                     res_valid  = 1'b1;
                     res_status = flvtp_pkg::ST_OFFSET_LOW;
                     phase_in   = flvtp_pkg::PH_HALT;
                  end else if (offset_in == flvtp_pkg::HDR_MIN_OFFSET) begin
                     phase_in = flvtp_pkg::PH_HPREV;
                  end else begin
                     count_in = offset_in - flvtp_pkg::HDR_MIN_OFFSET;
                     phase_in = flvtp_pkg::PH_HSKIP;
                  end
               end else begin
                  count_in = count_ff + 32'd1;
               end
            end
            flvtp_pkg::PH_HSKIP: begin
               count_in = count_ff - 32'd1;
               if (count_ff == 32'd1) begin
                  phase_in = flvtp_pkg::PH_HPREV;
               end
            end
            flvtp_pkg::PH_HPREV: begin
               prev_in = {prev_ff[23:0], b};
               if (count_ff[1:0] == 2'd3) begin
                  count_in  = '0;
                  res_valid = 1'b1;
                  if (prev_in != 32'd0) begin
                     res_status = flvtp_pkg::ST_HDR_PREVLEN;
                     phase_in   = flvtp_pkg::PH_HALT;
                  end else begin
                     res_status = flvtp_pkg::ST_HDR_OK;
                     phase_in   = flvtp_pkg::PH_TTYPE;
                  end
               end else begin
                  count_in = count_ff + 32'd1;
               end
            end
            flvtp_pkg::PH_TTYPE: begin
               type_in  = b;
               first_in = '0;
               count_in = '0;
               phase_in = flvtp_pkg::PH_TLEN;
            end
            flvtp_pkg::PH_TLEN: begin
               length_in = {length_ff[15:0], b};
               if (count_ff[1:0] == 2'd2) begin
                  count_in = '0;
                  phase_in = flvtp_pkg::PH_TSTAMP;
               end else begin
                  count_in = count_ff + 32'd1;
               end
            end
            flvtp_pkg::PH_TSTAMP: begin
               stamp_in = {stamp_ff[15:0], b};
               if (count_ff[1:0] == 2'd2) begin
                  count_in = '0;
                  phase_in = flvtp_pkg::PH_TRES;
               end else begin
                  count_in = count_ff + 32'd1;
               end
            end
            flvtp_pkg::PH_TRES: begin
               resvd_in = {resvd_ff[23:0], b};
               if (count_ff[1:0] == 2'd3) begin
                  if (length_ff == 24'd0) begin
                     count_in = '0;
                     phase_in = flvtp_pkg::PH_TPREV;
                  end else begin
                     count_in = {8'd0, length_ff};
                     phase_in = flvtp_pkg::PH_PAYLOAD;
                  end
               end else begin
                  count_in = count_ff + 32'd1;
               end
            end
            flvtp_pkg::PH_PAYLOAD: begin
               if (count_ff == {8'd0, length_ff}) begin
                  first_in = b;
               end
               count_in = count_ff - 32'd1;
               if (count_ff == 32'd1) begin
                  phase_in = flvtp_pkg::PH_TPREV;
               end
            end
            flvtp_pkg::PH_TPREV: begin
               prev_in = {prev_ff[23:0], b};
               if (count_ff[1:0] == 2'd3) begin
                  count_in  = '0;
                  res_valid = 1'b1;
                  if (prev_in != ({8'd0, length_ff} + flvtp_pkg::TAG_HDR_BYTES)) begin
                     res_status = flvtp_pkg::ST_TAG_PREVLEN;
                     phase_in   = flvtp_pkg::PH_HALT;
                  end else begin
                     res_status = flvtp_pkg::ST_TAG_OK;
                     phase_in   = flvtp_pkg::PH_TTYPE;
                  end
               end else begin
                  count_in = count_ff + 32'd1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // media flags of the first payload byte
   always_comb begin
      codec = '0;
      chans = '0;
      rate  = '0;
      ftype = '0;
      if (type_in == flvtp_pkg::TAG_AUDIO) begin
         codec = first_in[7:4];
         chans = {1'b0, first_in[0]} + 2'd1;
         rate  = flvtp_pkg::audio_rate(first_in[3:2]);
      end else if (type_in == flvtp_pkg::TAG_VIDEO) begin
         codec = first_in[3:0];
         ftype = first_in[7:4];
      end
   end

   assign res_data = {6'd0, ftype, rate, chans, codec, offset_in, flags_in,
                      version_in, resvd_in, stamp_in, length_in, type_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= flvtp_pkg::PH_SIG;
         count_ff   <= '0;
         offset_ff  <= '0;
         version_ff <= '0;
         flags_ff   <= '0;
         type_ff    <= '0;
         length_ff  <= '0;
         stamp_ff   <= '0;
         resvd_ff   <= '0;
         first_ff   <= '0;
         prev_ff    <= '0;
      end else begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         offset_ff  <= offset_in;
         version_ff <= version_in;
         flags_ff   <= flags_in;
         type_ff    <= type_in;
         length_ff  <= length_in;
         stamp_ff   <= stamp_in;
         resvd_ff   <= resvd_in;
         first_ff   <= first_in;
         prev_ff    <= prev_in;
      end
   end

   // spare register only fills while the result register is stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff  <= skid_valid_ff || res_valid;
         skid_valid_ff <= 1'b0;
      end else if (res_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            rsp_user_ff <= skid_user_ff;
            rsp_data_ff <= skid_data_ff;
         end else if (res_valid) begin
            rsp_user_ff <= res_status;
            rsp_data_ff <= res_data;
         end
      end else if (res_valid) begin
         skid_user_ff <= res_status;
         skid_data_ff <= res_data;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

>>> rtl/core/flvtp_checker.sv
// Port-level checker for the FLV tag stream parser, bound to the top level.
module flvtp_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [flvtp_pkg::RSP_W-1:0]    rsp_tdata,
   input logic [flvtp_pkg::STATUS_W-1:0] rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp beat changed while stalled");

   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !$past(rsp_tvalid) |-> $past(req_tvalid && req_tready))
      else $error("rsp beat without a req beat before it");

   a_halt: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready &&
      (rsp_tuser == flvtp_pkg::ST_BAD_SIG || rsp_tuser == flvtp_pkg::ST_OFFSET_LOW ||
       rsp_tuser == flvtp_pkg::ST_HDR_PREVLEN || rsp_tuser == flvtp_pkg::ST_TAG_PREVLEN)
      |=> !rsp_tvalid)
      else $error("result after an error beat");

   a_hdr_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == flvtp_pkg::ST_HDR_OK |-> rsp_tdata[87:0] == 88'd0)
      else $error("header result carries tag fields");

endmodule

bind flv_tag_stream_parser flvtp_checker u_flvtp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
